// ----- hw/rtl/tgf_pkg.sv -----
// Package for the trigamma function unit: shared widths, status codes and the
// command/status structs between controller and datapath. No dependencies.
package tgf_pkg;
	localparam int ArgW = 32;
	localparam int ResW = 64;
	localparam int StW = 2;
	localparam logic [StW-1:0] ST_VALID   = 2'd0;
	localparam logic [StW-1:0] ST_INVALID = 2'd1;
	localparam logic [StW-1:0] ST_SAT     = 2'd2;

	// Datapath operations issued by the controller.
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_RDIV   = 4'd2; // start 2^(32+2F)/a
	localparam logic [3:0] OP_RDIV2  = 4'd3; // start t/a
	localparam logic [3:0] OP_RACC   = 4'd4; // add recurrence term, a += 1
	localparam logic [3:0] OP_IDIV   = 4'd5; // start 2^(32+F)/a
	localparam logic [3:0] OP_MUL    = 4'd6; // next power of inv
	localparam logic [3:0] OP_TERM   = 4'd7; // add or subtract the series term of a power
	localparam logic [3:0] OP_SER    = 4'd8; // add series into sum

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] pw; // power index for OP_MUL / OP_TERM
	} tgf_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic below_lim; // a below the recurrence limit
		logic zero;      // argument is zero
		logic sat;
	} tgf_stat_t;
endpackage

// ----- hw/rtl/tgf_divider.sv -----
// Restoring divider, one quotient bit per cycle, with 64-bit saturation.
// Depends on tgf_pkg for widths.
module tgf_divider
	import tgf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [6:0]      nbits,     // index of the top dividend bit
	input  logic            pow2,      // dividend is 2^nbits when set
	input  logic [ResW-1:0] dividend,
	input  logic [33:0]     divisor,
	output logic            busy,
	output logic            ovf,       // one-cycle pulse after an overflowing division
	output logic [ResW-1:0] quot
);
	logic [6:0] idx_q;
	logic [33:0] rem_q;
	logic [ResW-1:0] num_q;
	logic [ResW-1:0] quot_q;
	logic busy_q, ovf_q, pow2_q, top_q;
	logic nb;
	logic [34:0] rnext, rsub;

	// A power-of-two dividend has its single one at the top bit.
	always_comb begin
		nb = pow2_q ? top_q : num_q[idx_q[5:0]];
		rnext = {rem_q, nb};
		rsub = rnext - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			quot_q <= '0;
			pow2_q <= 1'b0;
			top_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			ovf_q <= 1'b0;
			idx_q <= nbits;
			rem_q <= '0;
			num_q <= pow2 ? '0 : dividend;
			quot_q <= '0;
			pow2_q <= pow2;
			top_q <= 1'b1;
		end else if (busy_q) begin
			top_q <= 1'b0;
			if (quot_q[ResW-1]) begin
				// The next shift would lose a quotient bit, so the result is too wide.
				busy_q <= 1'b0;
				ovf_q <= 1'b1;
			end else begin
				if (rnext >= {1'b0, divisor}) begin
					rem_q <= rsub[33:0];
					quot_q <= {quot_q[ResW-2:0], 1'b1};
				end else begin
					rem_q <= rnext[33:0];
					quot_q <= {quot_q[ResW-2:0], 1'b0};
				end
				if (idx_q == 7'd0) busy_q <= 1'b0;
				else idx_q <= idx_q - 7'd1;
			end
		end else begin
			ovf_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign ovf = ovf_q;
	assign quot = quot_q;
endmodule

// ----- hw/rtl/tgf_datapath.sv -----
// Datapath of the trigamma unit: argument, sum, inverse powers, one shared
// divider and one multiplier. Depends on tgf_pkg and tgf_divider.
module tgf_datapath
	import tgf_pkg::*;
#(
	parameter int FracBits = 16
)(
	input  logic            clk,
	input  logic            arst_n,
	input  tgf_cmd_t        cmd,
	input  logic [ArgW-1:0] arg,
	output tgf_stat_t       stat,
	output logic [ResW-1:0] sum
);
	localparam logic [33:0] ALimit = 34'd8 << FracBits;
	localparam logic [33:0] AStep  = 34'd1 << FracBits;
	// Rounded-up reciprocals; exact for operands below 2^30, and the powers
	// never exceed 2^29.
	localparam logic [31:0] Recip6  = 32'd1431655766; // 2^33 / 6
	localparam logic [31:0] Recip30 = 32'd1145324613; // 2^35 / 30
	localparam logic [31:0] Recip42 = 32'd1636178018; // 2^36 / 42

	logic [33:0] a_q;
	logic [ResW-1:0] sum_q, inv_q, pcur_q, ser_q;
	logic sat_q, zero_q;
	logic dstart, dpow, dbusy, dovf;
	logic [6:0] dn;
	logic [ResW-1:0] dnum, quot;
	logic [31:0] mop;
	logic [ResW-1:0] prod;
	logic [ResW-1:0] term;
	logic neg;
	logic [64:0] addv;
	logic [ResW-1:0] addt;

	tgf_divider u_div (
		.clk, .arst_n, .start(dstart), .nbits(dn), .pow2(dpow),
		.dividend(dnum), .divisor(a_q), .busy(dbusy), .ovf(dovf), .quot(quot)
	);

	always_comb begin
		dstart = 1'b0;
		dpow = 1'b1;
		dn = 7'(32 + 2 * FracBits);
		dnum = '0;
		unique case (cmd.op)
			OP_RDIV: dstart = 1'b1;
			OP_RDIV2: begin
				dstart = 1'b1; dpow = 1'b0; dn = 7'd63; dnum = quot;
			end
			OP_IDIV: begin
				dstart = 1'b1; dn = 7'(32 + FracBits);
			end
			default: ;
		endcase
	end

	// Powers never exceed 2^29, so one 32x32 multiplier serves both the next
	// power and the division of a power by its series constant.
	always_comb begin
		mop = inv_q[31:0];
		if (cmd.op == OP_TERM) begin
			case (cmd.pw)
				4'd3: mop = Recip6;
				4'd7: mop = Recip42;
				default: mop = Recip30;
			endcase
		end
		prod = ResW'(pcur_q[31:0]) * ResW'(mop);
		case (cmd.pw)
			4'd2: term = pcur_q >> 1;
			4'd3: term = prod >> 33;
			4'd7: term = prod >> 36;
			default: term = prod >> 35;
		endcase
		neg = (cmd.pw == 4'd5) || (cmd.pw == 4'd9);
		addt = (cmd.op == OP_SER) ? ser_q : quot;
		addv = {1'b0, sum_q} + {1'b0, addt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LOAD) begin
				sat_q <= 1'b0;
				zero_q <= (arg == '0);
			end else if (dovf) sat_q <= 1'b1;
			else if ((cmd.op == OP_RACC || cmd.op == OP_SER) && addv[64]) sat_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			sum_q <= '0;
			inv_q <= '0;
			pcur_q <= '0;
			ser_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					a_q <= {2'b0, arg};
					sum_q <= '0;
				end
				OP_RACC: begin
					sum_q <= addv[ResW-1:0];
					a_q <= a_q + AStep;
				end
				OP_MUL: begin
					if (cmd.pw == 4'd1) begin
						inv_q <= quot; pcur_q <= quot; ser_q <= quot;
					end else pcur_q <= prod >> 32;
				end
				OP_TERM: ser_q <= neg ? ser_q - term : ser_q + term;
				OP_SER: sum_q <= addv[ResW-1:0];
				default: ;
			endcase
		end
	end

	// The overflow pulse is seen by the controller in the cycle it arrives.
	assign stat = '{div_busy: dbusy, below_lim: (a_q < ALimit),
		zero: zero_q, sat: (sat_q || dovf)};
	assign sum = sum_q;
endmodule

// ----- hw/rtl/tgf_ctrl.sv -----
// Controller state machine of the trigamma unit: sequences the recurrence,
// inverse, power and series steps. Depends on tgf_pkg.
module tgf_ctrl
	import tgf_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           out_free,
	input  tgf_stat_t      stat,
	output logic           busy,
	output logic           done,
	output tgf_cmd_t       cmd
);
	localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_RD1 = 4'd2, S_RD2 = 4'd3,
		S_RACC = 4'd4, S_IDV = 4'd5, S_PW = 4'd6, S_TM = 4'd7,
		S_SER = 4'd8, S_OUT = 4'd9, S_WAIT = 4'd10;
	logic [3:0] st_q, ret_q;
	logic [3:0] pw_q;
	logic term_pw;

	// Series terms: power 2,3,5,7,9 divided by 2,6,30,42,30.
	assign term_pw = (pw_q == 4'd2) || (pw_q == 4'd3) || (pw_q == 4'd5)
		|| (pw_q == 4'd7) || (pw_q == 4'd9);

	always_comb begin
		cmd = '{op: OP_NONE, pw: 4'd0};
		unique case (st_q)
			S_IDLE: if (in_fire) cmd.op = OP_LOAD;
			S_RD1: cmd.op = OP_RDIV;
			S_RD2: cmd.op = OP_RDIV2;
			S_RACC: cmd.op = OP_RACC;
			S_IDV: cmd.op = OP_IDIV;
			S_PW: cmd = '{op: OP_MUL, pw: pw_q};
			S_TM: cmd = '{op: OP_TERM, pw: pw_q};
			S_SER: cmd.op = OP_SER;
			default: ;
		endcase
	end

	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ret_q <= S_IDLE;
			pw_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_fire) st_q <= S_CHK;
				S_CHK: begin
					if (stat.zero || stat.sat) st_q <= S_OUT;
					else if (stat.below_lim) st_q <= S_RD1;
					else st_q <= S_IDV;
				end
				S_RD1: begin st_q <= S_WAIT; ret_q <= S_RD2; end
				S_RD2: begin st_q <= S_WAIT; ret_q <= S_RACC; end
				S_RACC: st_q <= S_CHK;
				S_IDV: begin st_q <= S_WAIT; ret_q <= S_PW; pw_q <= 4'd1; end
				S_WAIT: if (!stat.div_busy) st_q <= stat.sat ? S_OUT : ret_q;
				// Powers without a series term pass straight on.
				S_PW: begin
					if (term_pw) st_q <= S_TM;
					else pw_q <= pw_q + 4'd1;
				end
				S_TM: begin
					if (pw_q == 4'd9) st_q <= S_SER;
					else begin st_q <= S_PW; pw_q <= pw_q + 4'd1; end
				end
				S_SER: st_q <= S_OUT;
				S_OUT: if (out_free) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/trigamma_function_unit.sv -----
// Top level of the trigamma unit; ties tgf_ctrl and tgf_datapath to stream
// ports and an output register. Depends on tgf_pkg, tgf_ctrl and tgf_datapath.
//
// Usage: one request on s_axis (tdata = arg_value, unsigned Q16.16 at the
// default ARG_FRAC_BITS) gives one request on m_axis (tdata = result_value,
// Q32.32; tuser = result_status: 0 valid, 1 zero argument, 2 saturated).
// One request is worked on at a time, and the shared divider, one quotient bit
// a cycle, sets the latency. An argument of 8 or more passes through the
// inverse division, nine powers, five series terms and the final sum before
// m_axis_tvalid. Each recurrence step below 8 adds its two divisions, and
// there are at most eight. A zero argument goes from the check straight to
// the output; an argument of one LSB saturates in the first division and
// returns from there. s_axis_tready rises again in the same cycle as the
// result appears in the output register. Reset clears the controller and the
// output valid. While m_axis_tready is low the result is held in the output
// register; a further finished result waits behind it and no new request is
// taken until it leaves.
module trigamma_function_unit
	import tgf_pkg::*;
#(
	parameter int ARG_FRAC_BITS = 16
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [ArgW-1:0]   s_axis_tdata,  // arg_value
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [ResW-1:0]   m_axis_tdata,  // result_value
	output logic [StW-1:0]    m_axis_tuser   // result_status
);
	tgf_cmd_t cmd;
	tgf_stat_t stat;
	logic busy, done, in_fire, out_free;
	logic [ResW-1:0] sum;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	tgf_ctrl u_ctrl (.clk, .arst_n, .in_fire, .out_free, .stat, .busy, .done, .cmd);
	tgf_datapath #(.FracBits(ARG_FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd, .arg(s_axis_tdata), .stat, .sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (done && out_free) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			if (stat.zero) begin
				m_axis_tdata <= '0; m_axis_tuser <= ST_INVALID;
			end else if (stat.sat) begin
				m_axis_tdata <= '1; m_axis_tuser <= ST_SAT;
			end else begin
				m_axis_tdata <= sum; m_axis_tuser <= ST_VALID;
			end
		end
	end
endmodule

// ----- hw/rtl/tgf_checker.sv -----
// Port-level checker for the trigamma unit, bound to the top level.
// Depends on tgf_pkg.
module tgf_checker
	import tgf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [ResW-1:0] m_axis_tdata,
	input logic [StW-1:0] m_axis_tuser
);
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_VALID || m_axis_tuser == ST_INVALID
		|| m_axis_tuser == ST_SAT)) else $error("bad status");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_INVALID |-> m_axis_tdata == '0)
		else $error("invalid result not zero");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_SAT |-> m_axis_tdata == '1)
		else $error("saturated result not maximum");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");
endmodule

bind trigamma_function_unit tgf_checker u_chk (.*);

// ----- bench/testbench.sv -----
// Self-checking bench for trigamma_function_unit: drives arguments over the
// input stream, predicts trigamma in Q32.32 and checks every result.
// Depends on tgf_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module testbench
	import tgf_pkg::*;
();

	localparam int FracBits = 16;
	localparam longint unsigned CycleLimit = 12_000_000;

	typedef struct packed {
		logic [ResW-1:0] value;
		logic [StW-1:0]  status;
	} trigamma_res_t;

	logic            clk;
	logic            arst_n;
	logic            s_axis_tvalid;
	logic            s_axis_tready;
	logic [ArgW-1:0] s_axis_tdata;   // arg_value
	logic            m_axis_tvalid;
	logic            m_axis_tready;
	logic [ResW-1:0] m_axis_tdata;   // result_value
	logic [StW-1:0]  m_axis_tuser;   // result_status

	trigamma_res_t   expected_results[$];
	int              send_idle_pct;
	int              recv_idle_pct;
	int              hold_cycles;
	int              errors;
	longint unsigned cycles;

	trigamma_function_unit #(.ARG_FRAC_BITS(FracBits)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Trigamma of a Q16.16 argument, exact to the truncating fixed-point rules.
	function automatic trigamma_res_t trigamma_q32(input logic [ArgW-1:0] arg);
		trigamma_res_t   r;
		logic [127:0]    quo;
		longint unsigned a, sum, term, inv, p2, p3, p5, p7, p9, series;
		bit              sat;
		a = 64'(arg);
		sum = 0;
		sat = 0;
		if (a == 0) begin
			r.value = '0;
			r.status = ST_INVALID;
			return r;
		end
		while (a < (64'd8 << FracBits)) begin
			quo = (128'd1 << (32 + 2 * FracBits)) / a;
			if (quo[127:64] != 0) begin
				sat = 1;
				break;
			end
			term = quo[63:0] / a;
			if (sum > 64'hFFFF_FFFF_FFFF_FFFF - term) begin
				sat = 1;
				break;
			end
			sum += term;
			a += 64'd1 << FracBits;
		end
		if (!sat) begin
			inv = 64'((128'd1 << (32 + FracBits)) / a);
			p2 = (inv * inv) >> 32;
			p3 = (p2 * inv) >> 32;
			p5 = (((p3 * inv) >> 32) * inv) >> 32;
			p7 = (((p5 * inv) >> 32) * inv) >> 32;
			p9 = (((p7 * inv) >> 32) * inv) >> 32;
			series = inv + (p2 >> 1) + p3 / 6 + p7 / 42;
			series -= p5 / 30 + p9 / 30;
			if (sum > 64'hFFFF_FFFF_FFFF_FFFF - series)
				sat = 1;
			else
				sum += series;
		end
		if (sat) begin
			r.value = '1;
			r.status = ST_SAT;
		end else begin
			r.value = sum;
			r.status = ST_VALID;
		end
		return r;
	endfunction

	// Receiver side: random stalls, or a long counted hold-off when requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		trigamma_res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result value=%h status=%0d", m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (m_axis_tdata !== exp_r.value) begin
					$error("result_value: expected %h, got %h", exp_r.value, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== exp_r.status) begin
					$error("result_status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// Offers one argument, with an optional random gap first, until accepted.
	task automatic send_arg(input logic [ArgW-1:0] arg);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= arg;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(trigamma_q32(arg));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [ArgW-1:0] random_arg();
		int sel;
		sel = $urandom_range(99);
		if (sel < 5)
			return '0;
		else if (sel < 15)
			return $urandom_range(255, 1);
		else if (sel < 35)
			return $urandom_range(32'h7FFFF, 1);
		else
			return $urandom();
	endfunction

	task automatic test_directed();
		logic [ArgW-1:0] args[] = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFF, 32'h100,
			32'h8000, 32'hFFFF, 32'h10000, 32'h10001, 32'h18000, 32'h20000,
			32'h7FFFF, 32'h80000, 32'h80001, 32'hFFFFF, 32'h100000,
			32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFE, 32'hFFFFFFFF,
			32'hAAAAAAAA, 32'h55555555};
		send_idle_pct = 0;
		recv_idle_pct = 0;
		foreach (args[i])
			send_arg(args[i]);
		wait_drained();
	endtask

	task automatic test_random(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n)
			send_arg(random_arg());
		wait_drained();
	endtask

	// The receiver stalls for a long while so the output register fills and
	// the block refuses further requests.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		hold_cycles <= 4000;
		repeat (4)
			send_arg(32'h00100000 + $urandom_range(65535));
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		errors = 0;
		cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_backpressure();
		test_random(480, 27, 80);
		test_random(480, 80, 27);
		test_random(470, 0, 0);

		repeat (50) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// ----- trigamma_function_unit.f -----
hw/rtl/tgf_pkg.sv
hw/rtl/tgf_divider.sv
hw/rtl/tgf_datapath.sv
hw/rtl/tgf_ctrl.sv
hw/rtl/trigamma_function_unit.sv
hw/rtl/tgf_checker.sv
bench/testbench.sv
